// ===== sv/smx_pkg.sv =====
// shared types and widths for the softmax vector block
// no dependencies

package smx_pkg;

  localparam int LOGIT_W = 16;  // signed q8.8 logit
  localparam int EXP_W   = 17;  // unsigned q1.16 exponential
  localparam int PROB_W  = 16;  // unsigned q0.16 probability
  localparam int POS_W   = 6;   // element position on the result channel

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EXP_RD,
    ST_EXP_LU,
    ST_EXP_WR,
    ST_DIV_RD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } smx_state_t;

endpackage

// ===== sv/smx_exp_rom.sv =====
// exponential table, exp(-k/256) in unsigned q1.16, registered read
// depends on smx_pkg

module smx_exp_rom import smx_pkg::*; #(
  parameter int DEPTH = 4097
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  output logic [EXP_W-1:0]         data_r
);

  localparam logic [63:0] Q62_ONE = 64'd1 << 62;

  // (a * b) >> 62 in q2.62
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // floor(a / b) by shift and subtract, elaboration only
  function automatic logic [63:0] const_quot(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-1) by alternating series
  function automatic logic [63:0] exp_neg_one();
    logic [63:0] term;
    logic [63:0] acc;
    term = Q62_ONE;
    acc  = Q62_ONE;
    for (int n = 1; n < 64; n++) begin
      if (term != 64'd0) begin
        term = const_quot(term, 64'(n));
        if (n[0]) acc = acc - term;
        else acc = acc + term;
      end
    end
    return acc;
  endfunction

  // exp(-1/256) by alternating series
  function automatic logic [63:0] exp_neg_step();
    logic [63:0] term;
    logic [63:0] acc;
    term = Q62_ONE;
    acc  = Q62_ONE;
    for (int n = 1; n < 64; n++) begin
      if (term != 64'd0) begin
        term = const_quot(term, 64'd256 * 64'(n));
        if (n[0]) acc = acc - term;
        else acc = acc + term;
      end
    end
    return acc;
  endfunction

  localparam logic [63:0] E_ONE  = exp_neg_one();
  localparam logic [63:0] E_STEP = exp_neg_step();

  function automatic logic [EXP_W-1:0] exp_entry(input int k);
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] v;
    whole = Q62_ONE;
    frac  = Q62_ONE;
    for (int j = 0; j < (k >> 8); j++) whole = q62_mul(whole, E_ONE);
    for (int j = 0; j < (k & 255); j++) frac = q62_mul(frac, E_STEP);
    v = q62_mul(whole, frac);
    v = (v + (64'd1 << 45)) >> 46;
    return v[EXP_W-1:0];
  endfunction

  logic [EXP_W-1:0] rom_w [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    localparam logic [EXP_W-1:0] VAL = exp_entry(k);
    assign rom_w[k] = VAL;
  end

  always_ff @(posedge clk) begin
    data_r <= rom_w[addr];
  end

endmodule

// ===== sv/smx_div.sv =====
// iterative divider, floor(e * 65536 / sum) saturated to 16 bits, one bit a cycle
// depends on smx_pkg

module smx_div import smx_pkg::*; #(
  parameter int SUM_W = 21
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [EXP_W-1:0]  dividend,
  input  logic [SUM_W-1:0]  divisor,
  output logic              done_r,
  output logic [PROB_W-1:0] quotient
);

  localparam int STEP_W = $clog2(PROB_W);

  logic              busy_r, busy_nxt;
  logic              done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W:0]    rem_r, rem_nxt;
  logic [PROB_W-1:0] q_r, q_nxt;
  logic              sat_r, sat_nxt;
  logic [SUM_W:0]    rem_sh;
  logic [SUM_W:0]    div_ext;
  logic [SUM_W:0]    e_ext;
  logic              ge;

  assign div_ext = {1'b0, divisor};
  assign e_ext   = (SUM_W + 1)'(dividend);
  assign rem_sh  = {rem_r[SUM_W-1:0], 1'b0};
  assign ge      = rem_sh >= div_ext;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    sat_nxt  = sat_r;
    if (start) begin
      // integer part of e/sum is at most one
      sat_nxt  = e_ext >= div_ext;
      rem_nxt  = (e_ext >= div_ext) ? e_ext - div_ext : e_ext;
      q_nxt    = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? rem_sh - div_ext : rem_sh;
      q_nxt    = {q_r[PROB_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(PROB_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    sat_r <= sat_nxt;
  end

  assign quotient = sat_r ? '1 : q_r;

endmodule

// ===== sv/softmax_vector.sv =====
// softmax vector top level: load sequencer, logit and exponential memories, output register
// depends on smx_pkg, smx_exp_rom, smx_div
//
// max-subtracted softmax over a vector of signed q8.8 logits. logits come in one per
// transfer, one per cycle while loading, and are written to an on-chip memory while the
// running maximum is tracked; transfers beyond MAX_LEN are dropped. the transfer
// marked is_final closes the vector: the input then stalls while the block makes two
// passes over the stored elements. the first pass reads each logit, looks up
// round(65536*exp(-(max-x)/256)) in a table clamped at EXP_TABLE_DEPTH-1, writes it to
// a second memory and adds it to the sum, through read, lookup and write states per
// element. the second pass reads each exponential back and divides it by the sum with
// a bit-serial divider, through read, start, wait and emit states per element.
// results leave in load order as unsigned q0.16 with the position and an end mark on the
// last one; a full output register lets the next division run while a result waits.

module softmax_vector import smx_pkg::*; #(
  parameter int MAX_LEN         = 16,
  parameter int EXP_TABLE_DEPTH = 4097
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [LOGIT_W-1:0] in_logit,
  input  logic                      in_is_final,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [PROB_W-1:0]         out_probability,
  output logic [POS_W-1:0]          out_position,
  output logic                      out_end_of_vector
);

  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW    = $clog2(MAX_LEN + 1);
  localparam int SUM_W = EXP_W + $clog2(MAX_LEN);
  localparam int IW    = $clog2(EXP_TABLE_DEPTH);

  smx_state_t               state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic signed [LOGIT_W-1:0] max_r, max_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [PROB_W-1:0]        out_prob_r, out_prob_nxt;
  logic [POS_W-1:0]         out_pos_r, out_pos_nxt;
  logic                     out_eov_r, out_eov_nxt;

  // vector memories, registered read
  logic signed [LOGIT_W-1:0] logit_mem [MAX_LEN];
  logic [EXP_W-1:0]          exp_mem   [MAX_LEN];
  logic signed [LOGIT_W-1:0] logit_q_r;
  logic [EXP_W-1:0]          exp_q_r;

  logic                     in_xfer;
  logic                     has_room;
  logic                     is_last;
  logic                     exp_we;
  logic signed [LOGIT_W:0]  max_gap;
  logic [IW-1:0]            rom_addr;
  logic [EXP_W-1:0]         rom_q;
  logic                     div_start;
  logic                     div_done;
  logic [PROB_W-1:0]        div_quot;
  logic                     out_free;

  assign in_stall = (state_r != ST_LOAD);
  assign in_xfer  = in_valid && !in_stall;
  assign has_room = cnt_r < CW'(MAX_LEN);
  assign is_last  = (CW'(idx_r) == cnt_r - 1'b1);
  assign out_free = !out_valid_r || !out_stall;

  // distance from the maximum, clamped to the table end
  assign max_gap = {max_r[LOGIT_W-1], max_r} - {logit_q_r[LOGIT_W-1], logit_q_r};
  always_comb begin
    if (max_gap > (LOGIT_W + 1)'(EXP_TABLE_DEPTH - 1)) begin
      rom_addr = IW'(EXP_TABLE_DEPTH - 1);
    end else begin
      rom_addr = max_gap[IW-1:0];
    end
  end

  smx_exp_rom #(
    .DEPTH (EXP_TABLE_DEPTH)
  ) u_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (rom_q)
  );

  smx_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (exp_q_r),
    .divisor  (sum_r),
    .done_r   (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (in_xfer && has_room) begin
      logit_mem[cnt_r[AW-1:0]] <= in_logit;
    end
    logit_q_r <= logit_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (exp_we) begin
      exp_mem[idx_r] <= rom_q;
    end
    exp_q_r <= exp_mem[idx_r];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    idx_nxt       = idx_r;
    exp_we        = 1'b0;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_prob_nxt  = out_prob_r;
    out_pos_nxt   = out_pos_r;
    out_eov_nxt   = out_eov_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (has_room) begin
            if (cnt_r == '0 || in_logit > max_r) max_nxt = in_logit;
            cnt_nxt = cnt_r + 1'b1;
          end
          if (in_is_final) begin
            idx_nxt   = '0;
            state_nxt = ST_EXP_RD;
          end
        end
      end
      ST_EXP_RD: state_nxt = ST_EXP_LU;   // logit read in flight
      ST_EXP_LU: state_nxt = ST_EXP_WR;   // table read in flight
      ST_EXP_WR: begin
        exp_we  = 1'b1;
        sum_nxt = sum_r + SUM_W'(rom_q);
        if (is_last) begin
          idx_nxt   = '0;
          state_nxt = ST_DIV_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_EXP_RD;
        end
      end
      ST_DIV_RD: state_nxt = ST_DIV_GO;
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_prob_nxt  = div_quot;
          out_pos_nxt   = POS_W'(idx_r);
          out_eov_nxt   = is_last;
          if (is_last) begin
            // vector done, back to loading
            cnt_nxt   = '0;
            max_nxt   = {1'b1, {(LOGIT_W - 1){1'b0}}};
            sum_nxt   = '0;
            idx_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_DIV_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      max_r       <= {1'b1, {(LOGIT_W - 1){1'b0}}};
      sum_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, held while the transfer is stalled
  always_ff @(posedge clk) begin
    out_prob_r <= out_prob_nxt;
    out_pos_r  <= out_pos_nxt;
    out_eov_r  <= out_eov_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_probability   = out_prob_r;
  assign out_position      = out_pos_r;
  assign out_end_of_vector = out_eov_r;

endmodule

// ===== tb/sv/tb_softmax_vector.sv =====
// self-checking testbench for softmax_vector: directed and random logit vectors
// depends on smx_pkg and softmax_vector; builds its own exponential table to predict results
`timescale 1ns / 1ps

module tb_softmax_vector import smx_pkg::*; ();

  localparam int VEC_MAX   = 16;
  localparam int TAB_DEPTH = 4097;
  localparam int TAB_TOP   = TAB_DEPTH - 1;

  typedef struct packed {
    logic signed [LOGIT_W-1:0] logit;
    logic                      is_final;
  } logit_item_t;

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic [POS_W-1:0]  position;
    logic              end_of_vector;
  } prob_item_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [LOGIT_W-1:0] in_logit;
  logic                      in_is_final;
  logic                      out_valid;
  logic                      out_stall;
  logic [PROB_W-1:0]         out_probability;
  logic [POS_W-1:0]          out_position;
  logic                      out_end_of_vector;

  softmax_vector dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_logit(in_logit), .in_is_final(in_is_final),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_probability(out_probability), .out_position(out_position),
    .out_end_of_vector(out_end_of_vector)
  );

  // clock, 10 ns period
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  logit_item_t pending_logits[$];   // filled by the stimulus, drained by the driver
  prob_item_t  expected_probs[$];   // predicted results, oldest first
  int          errors;
  int          accepted_logits;
  logic        in_took;             // input transfer at the last rising edge

  // exponential table, q1.16, built with q2.62 integer arithmetic
  logic [EXP_W-1:0] exp_table[TAB_DEPTH];

  // predictor state for the vector being loaded
  logic signed [LOGIT_W-1:0] vec_logits[VEC_MAX];
  logic signed [LOGIT_W-1:0] vec_max;
  int                        vec_count;

  localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // exp(-1/d) by the alternating taylor series
  function automatic logic [63:0] exp_neg_inv(logic [63:0] d);
    logic [63:0] term;
    logic [63:0] acc;
    term = Q62_ONE;
    acc  = Q62_ONE;
    for (int n = 1; n < 64 && term != 0; n++) begin
      term = term / (d * n);
      if (n % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  task automatic fill_exp_table();
    logic [63:0] whole[TAB_TOP / 256 + 1];
    logic [63:0] frac[256];
    logic [63:0] e_one;
    logic [63:0] e_step;
    logic [63:0] v;
    e_one  = exp_neg_inv(64'd1);
    e_step = exp_neg_inv(64'd256);
    whole[0] = Q62_ONE;
    for (int k = 1; k <= TAB_TOP / 256; k++) whole[k] = q62_mul(whole[k-1], e_one);
    frac[0] = Q62_ONE;
    for (int k = 1; k < 256; k++) frac[k] = q62_mul(frac[k-1], e_step);
    for (int k = 0; k < TAB_DEPTH; k++) begin
      v = q62_mul(whole[k / 256], frac[k % 256]);
      v = (v + (64'd1 << 45)) >> 46;
      exp_table[k] = v[EXP_W-1:0];
    end
  endtask

  // takes one accepted logit; on the final one, predicts the whole vector
  task automatic predict_softmax(logic signed [LOGIT_W-1:0] x, logic fin);
    logic [EXP_W-1:0] e_vals[VEC_MAX];
    logic [23:0]      e_total;
    logic [63:0]      q;
    int               gap;
    prob_item_t       r;
    if (vec_count < VEC_MAX) begin
      vec_logits[vec_count] = x;
      if (vec_count == 0 || x > vec_max) vec_max = x;
      vec_count++;
    end
    if (!fin) return;
    e_total = '0;
    for (int i = 0; i < vec_count; i++) begin
      gap = int'(vec_max) - int'(vec_logits[i]);
      if (gap > TAB_TOP) gap = TAB_TOP;
      e_vals[i] = exp_table[gap];
      e_total   = e_total + e_vals[i];
    end
    for (int i = 0; i < vec_count; i++) begin
      q = 0;
      if (e_total != 0) q = ({47'd0, e_vals[i]} << 16) / {40'd0, e_total};
      if (q > 65535) q = 65535;
      r.probability   = q[PROB_W-1:0];
      r.position      = i[POS_W-1:0];
      r.end_of_vector = (i + 1 == vec_count);
      expected_probs = {expected_probs, r};
    end
    vec_count = 0;
  endtask

  // idling: phase by progress - sender light/receiver heavy, swapped, then none
  function automatic int send_idle_pct();
    if (accepted_logits < 80) return 21;
    if (accepted_logits < 160) return 70;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (accepted_logits < 80) return 70;
    if (accepted_logits < 160) return 21;
    return 0;
  endfunction

  // driver: changes inputs on the falling edge, holds a stalled transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_logits.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
        in_logit    <= pending_logits[0].logit;
        in_is_final <= pending_logits[0].is_final;
        in_valid    <= 1'b1;
        void'(pending_logits.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct());
  end

  // input side: feed every transfer to the predictor
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      predict_softmax(in_logit, in_is_final);
      accepted_logits++;
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    prob_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_probs.size() == 0) begin
        $display("%0t: unexpected result prob=%0d pos=%0d end=%0b", $time,
                 out_probability, out_position, out_end_of_vector);
        errors++;
      end else begin
        want = expected_probs.pop_front();
        if (out_probability !== want.probability) begin
          $display("%0t: probability expected %0d actual %0d", $time,
                   want.probability, out_probability);
          errors++;
        end
        if (out_position !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time,
                   want.position, out_position);
          errors++;
        end
        if (out_end_of_vector !== want.end_of_vector) begin
          $display("%0t: end_of_vector expected %0b actual %0b", $time,
                   want.end_of_vector, out_end_of_vector);
          errors++;
        end
      end
    end
  end

  task automatic queue_logit(logic signed [LOGIT_W-1:0] x, logic fin);
    logit_item_t it;
    it.logit    = x;
    it.is_final = fin;
    pending_logits = {pending_logits, it};
  endtask

  // random vector: mostly clustered logits so the table is exercised across its range
  task automatic queue_random_vector();
    int len;
    int centre;
    int spread;
    int v;
    len    = ($urandom_range(9) == 0) ? $urandom_range(24, 17) : $urandom_range(16, 1);
    centre = $urandom_range(65535) - 32768;
    spread = ($urandom_range(3) == 0) ? 32767 : $urandom_range(4096, 16);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(7) == 0) v = $urandom_range(65535) - 32768;
      else v = centre + $urandom_range(2 * spread) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      queue_logit(v[LOGIT_W-1:0], i == len - 1);
    end
  endtask

  initial begin
    errors          = 0;
    accepted_logits = 0;
    vec_count       = 0;
    vec_max         = '0;
    in_took         = 1'b0;
    in_valid        = 1'b0;
    in_logit        = '0;
    in_is_final     = 1'b0;
    out_stall       = 1'b0;
    rst_n           = 1'b0;
    fill_exp_table();

    // directed: single element saturates to full scale
    queue_logit(16'sh1234, 1'b1);
    // field extremes together, distance clamped at the table end
    queue_logit(-16'sd32768, 1'b0);
    queue_logit(16'sd32767, 1'b0);
    queue_logit(16'sd0, 1'b1);
    // equal logits share evenly
    for (int i = 0; i < 4; i++) queue_logit(16'sh0100, i == 3);
    // overflow: elements past the vector length are dropped, final still closes it
    for (int i = 0; i < 18; i++) queue_logit(16'(i * 37 - 300), i == 17);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_logits + pending_logits.size() < 220) queue_random_vector();

    while (pending_logits.size() > 0 || in_valid || expected_probs.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_probs.size() == 0) begin
      $display("tb_softmax_vector: clean");
    end else begin
      $display("tb_softmax_vector: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb_softmax_vector: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/smx_pkg.sv
sv/smx_exp_rom.sv
sv/smx_div.sv
sv/softmax_vector.sv
tb/sv/tb_softmax_vector.sv
